// ===== src/term_cover_window_finder_top_defines.svh =====
// ----------------------------------------------------------------------------
// Term cover window finder assertion macros
// Assertion helpers shared by the RTL files; they compile to nothing when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TERM_COVER_WINDOW_FINDER_TOP_DEFINES_SVH
`define TERM_COVER_WINDOW_FINDER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define TCWF_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("assertion failed");
`define TCWF_ASSERT_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("forbidden condition seen");
`else
`define TCWF_ASSERT(lbl, clk, rstn, prop)
`define TCWF_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

// ===== src/tcwf_pkg.sv =====
// ----------------------------------------------------------------------------
// Term cover window finder package
// Shared constants and types of the window finder.
// ----------------------------------------------------------------------------
package tcwf_pkg;

	localparam int MAX_TERMS_DEF = 16;
	localparam int POS_WIDTH_DEF = 16;
	localparam int TERM_IDX_W    = 4;
	localparam int TERM_CNT_W    = 5;
	localparam int APB_DATA_W    = 32;
	localparam int APB_ADDR_W    = 3;
	localparam int GRP_SIZE      = 4;

	localparam logic [TERM_CNT_W-1:0] TERM_COUNT_RST = TERM_CNT_W'(1);

	typedef enum logic {
		REG_TERM_COUNT = 1'b0
	} reg_sel_t;

endpackage

// ===== src/tcwf_ifs.sv =====
// ----------------------------------------------------------------------------
// Term cover window finder channels
// Valid/ready channels for term hit requests and window results.
// ----------------------------------------------------------------------------
interface tcwf_hit_if import tcwf_pkg::*; #(
	parameter int POS_W = POS_WIDTH_DEF
) ();
	logic                  valid;
	logic                  ready;
	logic [TERM_IDX_W-1:0] term_index;
	logic [POS_W-1:0]      word_position;
	logic                  first_of_query;

	modport source (output valid, term_index, word_position, first_of_query, input ready);
	modport sink (input valid, term_index, word_position, first_of_query, output ready);
endinterface

interface tcwf_win_if import tcwf_pkg::*; #(
	parameter int POS_W = POS_WIDTH_DEF
) ();
	logic             valid;
	logic             ready;
	logic [POS_W-1:0] window_start;
	logic [POS_W-1:0] window_end;

	modport source (output valid, window_start, window_end, input ready);
	modport sink (input valid, window_start, window_end, output ready);
endinterface

// ===== src/tcwf_cfg.sv =====
// ----------------------------------------------------------------------------
// Term cover window finder register file
// APB-style port holding the term count register.
// ----------------------------------------------------------------------------
module tcwf_cfg import tcwf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic [TERM_CNT_W-1:0] term_count
);
	logic [TERM_CNT_W-1:0] term_count_q;
	reg_sel_t              sel;
	logic                  wr_en;

	always_comb begin
		sel    = reg_sel_t'(paddr[APB_ADDR_W-1]);
		wr_en  = 1'b0;
		prdata = '0;
		case (sel)
			REG_TERM_COUNT: begin
				wr_en  = psel && penable && pwrite;
				prdata = APB_DATA_W'(term_count_q);
			end
			default: begin
				wr_en  = 1'b0;
				prdata = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_count_q <= TERM_COUNT_RST;
		end else if (wr_en) begin
			term_count_q <= pwdata[TERM_CNT_W-1:0];
		end
	end

	assign pready     = 1'b1;
	assign term_count = term_count_q;
endmodule

// ===== src/tcwf_cover.sv =====
// ----------------------------------------------------------------------------
// Term cover window finder update stage
// Registers each hit, updates the seen bits and latest positions, detects a
// full cover and reduces the positions to per-group minimum and maximum.
// ----------------------------------------------------------------------------
`include "term_cover_window_finder_top_defines.svh"

module tcwf_cover import tcwf_pkg::*; #(
	parameter int MAX_TERMS = MAX_TERMS_DEF,
	parameter int POS_WIDTH = POS_WIDTH_DEF,
	parameter int NUM_GRP   = (MAX_TERMS_DEF + GRP_SIZE - 1) / GRP_SIZE
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [TERM_CNT_W-1:0]             term_count,
	tcwf_hit_if.sink                          hit,
	output logic                              s2_valid,
	input  logic                              s2_ready,
	output logic [NUM_GRP-1:0][POS_WIDTH-1:0] grp_lo,
	output logic [NUM_GRP-1:0][POS_WIDTH-1:0] grp_hi,
	output logic [NUM_GRP-1:0]                grp_en
);
	localparam int LEAVES = NUM_GRP * GRP_SIZE;

	logic                  valid_s1;
	logic [TERM_IDX_W-1:0] idx_s1;
	logic [POS_WIDTH-1:0]  pos_s1;
	logic                  foq_s1;

	logic [MAX_TERMS-1:0]                seen_q;
	logic [MAX_TERMS-1:0][POS_WIDTH-1:0] pos_q;

	logic [MAX_TERMS-1:0]                en;
	logic [MAX_TERMS-1:0]                hit_vec;
	logic [MAX_TERMS-1:0]                seen_nx;
	logic [MAX_TERMS-1:0][POS_WIDTH-1:0] pos_nx;
	logic                                idx_ok;
	logic                                fire;
	logic                                s2_rdy;
	logic                                consume;

	logic [LEAVES-1:0]                en_l;
	logic [LEAVES-1:0][POS_WIDTH-1:0] pos_l;
	logic [NUM_GRP-1:0][POS_WIDTH-1:0] lo_c;
	logic [NUM_GRP-1:0][POS_WIDTH-1:0] hi_c;
	logic [NUM_GRP-1:0]                gen_c;

	logic                              valid_s2;
	logic [NUM_GRP-1:0][POS_WIDTH-1:0] lo_s2;
	logic [NUM_GRP-1:0][POS_WIDTH-1:0] hi_s2;
	logic [NUM_GRP-1:0]                en_s2;

	// A term takes part when its index is below the term count; term zero
	// always does, and indexes past the storage never do.
	always_comb begin
		idx_ok = 1'b0;
		for (int k = 0; k < MAX_TERMS; k++) begin
			en[k]      = (k == 0) || (k < int'(term_count));
			hit_vec[k] = (int'(idx_s1) == k);
			if (hit_vec[k] && en[k]) begin
				idx_ok = 1'b1;
			end
		end
		seen_nx = (foq_s1 ? '0 : seen_q) | (idx_ok ? hit_vec : '0);
		fire    = idx_ok && ((seen_nx & en) == en);
		for (int k = 0; k < MAX_TERMS; k++) begin
			pos_nx[k] = (idx_ok && hit_vec[k]) ? pos_s1 : pos_q[k];
		end
	end

	always_comb begin
		for (int k = 0; k < LEAVES; k++) begin
			en_l[k]  = 1'b0;
			pos_l[k] = '0;
		end
		for (int k = 0; k < MAX_TERMS; k++) begin
			en_l[k]  = en[k];
			pos_l[k] = pos_nx[k];
		end
		for (int g = 0; g < NUM_GRP; g++) begin
			lo_c[g]  = '0;
			hi_c[g]  = '0;
			gen_c[g] = 1'b0;
			for (int j = 0; j < GRP_SIZE; j++) begin
				if (en_l[g*GRP_SIZE+j]) begin
					if (!gen_c[g] || (pos_l[g*GRP_SIZE+j] < lo_c[g])) begin
						lo_c[g] = pos_l[g*GRP_SIZE+j];
					end
					if (!gen_c[g] || (pos_l[g*GRP_SIZE+j] > hi_c[g])) begin
						hi_c[g] = pos_l[g*GRP_SIZE+j];
					end
					gen_c[g] = 1'b1;
				end
			end
		end
	end

	assign s2_rdy    = !valid_s2 || s2_ready;
	assign consume   = valid_s1 && s2_rdy;
	assign hit.ready = !valid_s1 || s2_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			seen_q   <= '0;
		end else begin
			if (hit.ready) begin
				valid_s1 <= hit.valid;
			end
			if (s2_rdy) begin
				valid_s2 <= valid_s1 && fire;
			end
			if (consume) begin
				seen_q <= fire ? '0 : seen_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hit.valid && hit.ready) begin
			idx_s1 <= hit.term_index;
			pos_s1 <= hit.word_position;
			foq_s1 <= hit.first_of_query;
		end
		if (consume) begin
			pos_q <= pos_nx;
		end
		if (consume && fire) begin
			lo_s2 <= lo_c;
			hi_s2 <= hi_c;
			en_s2 <= gen_c;
		end
	end

	assign s2_valid = valid_s2;
	assign grp_lo   = lo_s2;
	assign grp_hi   = hi_s2;
	assign grp_en   = en_s2;

	`TCWF_ASSERT(ap_seen_cleared, clk, arst_n, (consume && fire) |=> (seen_q == '0))
	`TCWF_ASSERT(ap_group0_used, clk, arst_n, valid_s2 |-> en_s2[0])
	`TCWF_ASSERT_NEVER(ap_fire_bad_index, clk, arst_n, valid_s1 && fire && !idx_ok)
endmodule

// ===== src/tcwf_reduce.sv =====
// ----------------------------------------------------------------------------
// Term cover window finder result stage
// Combines the per-group extremes into one window and holds it in the
// output register until the sink takes it.
// ----------------------------------------------------------------------------
`include "term_cover_window_finder_top_defines.svh"

module tcwf_reduce import tcwf_pkg::*; #(
	parameter int POS_WIDTH = POS_WIDTH_DEF,
	parameter int NUM_GRP   = (MAX_TERMS_DEF + GRP_SIZE - 1) / GRP_SIZE
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s2_valid,
	output logic                              s2_ready,
	input  logic [NUM_GRP-1:0][POS_WIDTH-1:0] grp_lo,
	input  logic [NUM_GRP-1:0][POS_WIDTH-1:0] grp_hi,
	input  logic [NUM_GRP-1:0]                grp_en,
	tcwf_win_if.source                        win
);
	logic                 valid_s3;
	logic [POS_WIDTH-1:0] start_s3;
	logic [POS_WIDTH-1:0] end_s3;
	logic [POS_WIDTH-1:0] lo_c;
	logic [POS_WIDTH-1:0] hi_c;
	logic                 any_c;

	always_comb begin
		lo_c  = '0;
		hi_c  = '0;
		any_c = 1'b0;
		for (int g = 0; g < NUM_GRP; g++) begin
			if (grp_en[g]) begin
				if (!any_c || (grp_lo[g] < lo_c)) begin
					lo_c = grp_lo[g];
				end
				if (!any_c || (grp_hi[g] > hi_c)) begin
					hi_c = grp_hi[g];
				end
				any_c = 1'b1;
			end
		end
	end

	assign s2_ready = !valid_s3 || win.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (s2_ready) begin
			valid_s3 <= s2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_valid && s2_ready) begin
			start_s3 <= lo_c;
			end_s3   <= hi_c;
		end
	end

	assign win.valid        = valid_s3;
	assign win.window_start = start_s3;
	assign win.window_end   = end_s3;

	`TCWF_ASSERT(ap_window_order, clk, arst_n, valid_s3 |-> (start_s3 <= end_s3))
	`TCWF_ASSERT(ap_result_loaded, clk, arst_n, (s2_valid && s2_ready) |=> valid_s3)
	`TCWF_ASSERT_NEVER(ap_empty_reduce, clk, arst_n, s2_valid && !any_c)
endmodule

// ===== src/term_cover_window_finder_top.sv =====
// ----------------------------------------------------------------------------
// Term cover window finder
// Tracks which query terms have been hit and their latest positions, and
// emits the span of those positions each time every term has been seen.
//
//   Channel  Direction  Handshake       Contents
//   hit      in         valid/ready     term_index, word_position, first_of_query
//   win      out        valid/ready     window_start, window_end
//   cfg      in         APB write/read  term_count at byte address 0
//
// One hit request is taken every cycle while hit ready is high; the cover
// check and the per-group min/max over groups of four terms run in the
// update stage, and the group results are merged in the result stage.
// A completing hit goes through the input, update and result registers.
// Reset clears the seen bits, the stage valids and sets term_count to one.
// A stalled output holds its window; the stages behind it keep filling until
// each is occupied, then the hit channel drops ready.
// ----------------------------------------------------------------------------
module term_cover_window_finder_top import tcwf_pkg::*; #(
	parameter int MAX_TERMS = MAX_TERMS_DEF,
	parameter int POS_WIDTH = POS_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	tcwf_hit_if.sink              hit,
	tcwf_win_if.source            win,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);
	localparam int NUM_GRP = (MAX_TERMS + GRP_SIZE - 1) / GRP_SIZE;

	logic [TERM_CNT_W-1:0]             term_count;
	logic                              s2_valid;
	logic                              s2_ready;
	logic [NUM_GRP-1:0][POS_WIDTH-1:0] grp_lo;
	logic [NUM_GRP-1:0][POS_WIDTH-1:0] grp_hi;
	logic [NUM_GRP-1:0]                grp_en;

	tcwf_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.term_count (term_count)
	);

	tcwf_cover #(
		.MAX_TERMS (MAX_TERMS),
		.POS_WIDTH (POS_WIDTH),
		.NUM_GRP   (NUM_GRP)
	) u_cover (
		.clk        (clk),
		.arst_n     (arst_n),
		.term_count (term_count),
		.hit        (hit),
		.s2_valid   (s2_valid),
		.s2_ready   (s2_ready),
		.grp_lo     (grp_lo),
		.grp_hi     (grp_hi),
		.grp_en     (grp_en)
	);

	tcwf_reduce #(
		.POS_WIDTH (POS_WIDTH),
		.NUM_GRP   (NUM_GRP)
	) u_reduce (
		.clk      (clk),
		.arst_n   (arst_n),
		.s2_valid (s2_valid),
		.s2_ready (s2_ready),
		.grp_lo   (grp_lo),
		.grp_hi   (grp_hi),
		.grp_en   (grp_en),
		.win      (win)
	);
endmodule

// ===== tb/sv/tcwf_window_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Term cover window checker
// Watches the hit and window channels and the register port of the window
// finder. It keeps its own copy of the seen terms, the latest positions and
// term_count, predicts the window that each accepted hit completes, and
// compares every accepted window with the oldest prediction. Register reads
// are compared with the last value written.
// ----------------------------------------------------------------------------
module tcwf_window_checker import tcwf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	tcwf_hit_if                   hit,
	tcwf_win_if                   win,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	input  logic [APB_DATA_W-1:0] prdata,
	input  logic                  pready,
	output int                    mismatches,
	output int                    windows_pending
);

	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [POS_WIDTH_DEF-1:0] lo;
		logic [POS_WIDTH_DEF-1:0] hi;
	} window_t;

	window_t                  expected_windows[$];
	logic [MAX_TERMS_DEF-1:0] seen_terms;
	logic [POS_WIDTH_DEF-1:0] latest_pos [MAX_TERMS_DEF];
	logic [TERM_CNT_W-1:0]    term_count_reg;

	function automatic int active_terms(input logic [TERM_CNT_W-1:0] cnt);
		if (cnt == 0) begin
			return 1;
		end
		if (int'(cnt) > MAX_TERMS_DEF) begin
			return MAX_TERMS_DEF;
		end
		return int'(cnt);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int      n;
		bit      covered;
		window_t w;
		if (!arst_n) begin
			seen_terms     = '0;
			term_count_reg = TERM_COUNT_RST;
			expected_windows.delete();
			windows_pending = 0;
			mismatches      = 0;
		end else begin
			if (hit.valid && hit.ready) begin
				n = active_terms(term_count_reg);
				if (hit.first_of_query) begin
					seen_terms = '0;
				end
				if (int'(hit.term_index) < n) begin
					seen_terms[hit.term_index] = 1'b1;
					latest_pos[hit.term_index] = hit.word_position;
					covered = 1'b1;
					for (int k = 0; k < n; k++) begin
						if (!seen_terms[k]) begin
							covered = 1'b0;
						end
					end
					if (covered) begin
						w.lo = latest_pos[0];
						w.hi = latest_pos[0];
						for (int k = 1; k < n; k++) begin
							if (latest_pos[k] < w.lo) begin
								w.lo = latest_pos[k];
							end
							if (latest_pos[k] > w.hi) begin
								w.hi = latest_pos[k];
							end
						end
						seen_terms = '0;
						expected_windows = {expected_windows, w};
					end
				end
			end
			if (win.valid && win.ready) begin
				if (expected_windows.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("Unexpected window: start %0d end %0d",
							win.window_start, win.window_end);
					end
				end else begin
					w = expected_windows.pop_front();
					if (win.window_start !== w.lo || win.window_end !== w.hi) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS) begin
							$display("Window mismatch: expected %0d..%0d, got %0d..%0d",
								w.lo, w.hi, win.window_start, win.window_end);
						end
					end
				end
			end
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr == APB_ADDR_W'(4 * int'(REG_TERM_COUNT))) begin
						term_count_reg = pwdata[TERM_CNT_W-1:0];
					end
				end else if (prdata !== APB_DATA_W'(term_count_reg)) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("Register read mismatch: expected %0d, got %0d",
							term_count_reg, prdata);
					end
				end
			end
			windows_pending = expected_windows.size();
		end
	end

endmodule

// ===== tb/sv/tb_term_cover_window_finder_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Term cover window finder testbench
// Drives term hit requests and term_count writes into the window finder and
// lets the checker predict and compare the windows. A short directed part
// covers the field extremes, a zero and an oversized term count, ignored
// hits that still clear the seen terms and a count change between hits.
// Random queries with ascending positions follow, mixed with noise, under
// random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb_term_cover_window_finder_top;
	import tcwf_pkg::*;

	localparam int DRAIN_CYCLES     = 8;
	localparam int WATCHDOG_LIMIT   = 5000;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int PHASE_HITS       = 150;
	localparam int PHASES           = 12;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	int                    mismatches;
	int                    windows_pending;
	bit                    hit_idle_on = 1'b1;
	bit                    win_idle_on = 1'b1;
	bit                    long_hold_req = 1'b0;

	tcwf_hit_if hit_ch ();
	tcwf_win_if win_ch ();

	term_cover_window_finder_top DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.hit     (hit_ch),
		.win     (win_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	tcwf_window_checker window_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.hit             (hit_ch),
		.win             (win_ch),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.mismatches      (mismatches),
		.windows_pending (windows_pending)
	);

	always #5 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 85) begin
			return $urandom_range(1, 3);
		end
		if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	task automatic send_hit(input logic [TERM_IDX_W-1:0] idx,
			input logic [POS_WIDTH_DEF-1:0] pos, input logic first);
		int gap;
		gap = hit_idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			hit_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		hit_ch.valid          = 1'b1;
		hit_ch.term_index     = idx;
		hit_ch.word_position  = pos;
		hit_ch.first_of_query = first;
		do @(posedge clk); while (!hit_ch.ready);
		@(negedge clk);
	endtask

	task automatic settle();
		hit_ch.valid = 1'b0;
		wait (windows_pending == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic apb_write(input reg_sel_t sel, input logic [APB_DATA_W-1:0] data);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = APB_ADDR_W'(4 * int'(sel));
		pwdata  = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic apb_read(input reg_sel_t sel);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = APB_ADDR_W'(4 * int'(sel));
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	initial begin : win_side
		int hold_left;
		hold_left    = 0;
		win_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left     = LONG_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				win_ch.ready = 1'b0;
				hold_left--;
			end else if (win_idle_on && $urandom_range(0, 99) < 25) begin
				win_ch.ready = 1'b0;
				hold_left    = pick_gap();
			end else begin
				win_ch.ready = 1'b1;
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((hit_ch.valid && hit_ch.ready) || (win_ch.valid && win_ch.ready)
					|| (psel && penable)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("FAILURE");
		$finish;
	end

	initial begin : stimulus
		int                       term_plan [PHASES];
		int                       n;
		int                       sent;
		int                       len;
		logic [TERM_IDX_W-1:0]    idx;
		logic [POS_WIDTH_DEF-1:0] cursor;
		term_plan = '{1, 16, 0, 31, 2, 7, 17, 4, 16, 3, 1, 9};
		term_plan[5]  = $urandom_range(2, 15);
		term_plan[11] = $urandom_range(2, 15);
		cursor                = '0;
		hit_ch.valid          = 1'b0;
		hit_ch.term_index     = '0;
		hit_ch.word_position  = '0;
		hit_ch.first_of_query = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		arst_n  = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		apb_read(REG_TERM_COUNT);
		send_hit(4'd0, 16'd0, 1'b1);
		send_hit(4'd1, 16'd7, 1'b0);
		send_hit(4'd0, 16'hFFFF, 1'b0);
		settle();
		apb_write(REG_TERM_COUNT, 0);
		apb_read(REG_TERM_COUNT);
		send_hit(4'd15, 16'd3, 1'b1);
		send_hit(4'd0, 16'd9, 1'b0);
		settle();
		apb_write(REG_TERM_COUNT, 31);
		apb_read(REG_TERM_COUNT);
		send_hit(4'd15, 16'd100, 1'b1);
		for (int k = 0; k < 15; k++) begin
			send_hit(TERM_IDX_W'(k), (k == 14) ? 16'hFFFF : 16'(200 + k), 1'b0);
		end
		settle();
		apb_write(REG_TERM_COUNT, 3);
		send_hit(4'd0, 16'd20, 1'b1);
		send_hit(4'd1, 16'd21, 1'b0);
		settle();
		apb_write(REG_TERM_COUNT, 2);
		send_hit(4'd1, 16'd22, 1'b0);
		send_hit(4'd0, 16'd30, 1'b0);
		send_hit(4'd5, 16'd31, 1'b1);
		send_hit(4'd1, 16'd32, 1'b0);

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			apb_write(REG_TERM_COUNT, term_plan[ph]);
			apb_read(REG_TERM_COUNT);
			n = (term_plan[ph] == 0) ? 1 :
				(term_plan[ph] > MAX_TERMS_DEF) ? MAX_TERMS_DEF : term_plan[ph];
			hit_idle_on = (ph % 3 != 1);
			win_idle_on = (ph % 3 != 1);
			if (ph == 0) begin
				hit_idle_on   = 1'b0;
				long_hold_req = 1'b1;
			end
			sent = 0;
			while (sent < PHASE_HITS) begin
				if ($urandom_range(0, 99) < 80) begin
					len = $urandom_range(1, 5 * n + 2);
					if ($urandom_range(0, 9) == 0) begin
						cursor = POS_WIDTH_DEF'($urandom);
					end
					for (int k = 0; k < len; k++) begin
						cursor = cursor + POS_WIDTH_DEF'($urandom_range(0, 20));
						send_hit(TERM_IDX_W'($urandom_range(0, n - 1)), cursor, k == 0);
					end
					sent += len;
				end else begin
					idx = TERM_IDX_W'($urandom_range(0, 15));
					send_hit(idx, POS_WIDTH_DEF'($urandom), $urandom_range(0, 4) == 0);
					if (int'(idx) < n) begin
						sent++;
					end
				end
			end
		end

		settle();
		if (mismatches == 0 && windows_pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
